>>> rtl/qred_pkg.sv
// Package: shared constants, lane status type and transition table for the encoder decoder.
package qred_pkg;

  localparam int DEF_CHANNELS = 4;
  localparam int PIN_BITS     = 4;
  localparam int CHAN_W       = 2;

  // Bit n set when previous/next code n is a legal quadrature move.
  localparam logic [15:0] VALID_MOVE = 16'b0110_1001_1001_0110;

  localparam logic [7:0] HIST_CCW = 8'h2b;
  localparam logic [7:0] HIST_CW  = 8'h17;

  localparam logic signed [7:0] COUNT_MAX = 8'sd127;
  localparam logic signed [7:0] COUNT_MIN = -8'sd127;

  localparam logic signed [1:0] STEP_ZERO = 2'sb00;
  localparam logic signed [1:0] STEP_CW   = 2'sb01;
  localparam logic signed [1:0] STEP_CCW  = 2'sb11;

  typedef struct packed {
    logic pos;
    logic neg;
  } lane_status_t;

endpackage

>>> rtl/qred_lane.sv
// Per-channel decode lane: transition code, history and saturating pending count.
module qred_lane import qred_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample,
  input  logic         consume,
  input  logic         a,
  input  logic         b,
  output lane_status_t status
);

  logic [3:0]        code;
  logic [7:0]        hist;
  logic signed [7:0] count;

  logic [3:0]        code_next;
  logic [7:0]        hist_next;
  logic              move_ok;
  logic signed [7:0] count_next;

  always_comb begin
    code_next  = {code[1:0], a, b};
    move_ok    = VALID_MOVE[code_next];
    hist_next  = {hist[3:0], code_next};
    count_next = count;
    if (sample && move_ok) begin
      if (hist_next == HIST_CW && count != COUNT_MAX) begin
        count_next = count + 8'sd1;
      end else if (hist_next == HIST_CCW && count != COUNT_MIN) begin
        count_next = count - 8'sd1;
      end
    end else if (consume) begin
      // take one unit toward zero
      if (status.pos) begin
        count_next = count - 8'sd1;
      end else if (status.neg) begin
        count_next = count + 8'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code  <= '0;
      hist  <= '0;
      count <= '0;
    end else begin
      if (sample) begin
        code <= code_next;
        if (move_ok) begin
          hist <= hist_next;
        end
      end
      count <= count_next;
    end
  end

  assign status.pos = (count > 8'sd0);
  assign status.neg = count[7];

endmodule

>>> rtl/qred_merge.sv
// Merge stage: selects the consumed lane's step and holds it in the output register.
module qred_merge import qred_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst,
  input  lane_status_t       lane_status [CHANNELS],
  input  logic [CHAN_W-1:0]  channel,
  input  logic               load,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [1:0]  step
);

  lane_status_t     sel;
  logic signed [1:0] step_next;
  logic              valid_next;

  always_comb begin
    sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(channel) == i) begin
        sel = lane_status[i];
      end
    end
    if (sel.pos) begin
      step_next = STEP_CW;
    end else if (sel.neg) begin
      step_next = STEP_CCW;
    end else begin
      step_next = STEP_ZERO;
    end
  end

  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (out_stall) begin
      valid_next = out_valid;
    end else begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/quad_rotary_encoder_decoder_top.sv
// Top level: quadrature encoder decoder with one lane per channel and a merged step output.
// A consume item's step is registered in the merge stage and appears in the cycle after acceptance.
// Throughput: one item per cycle while in_stall is low; a sample updates every lane in the cycle it is accepted.
// Input stall follows the output register: held only while a step waits and out_stall is high.
// Reset clears transition codes, histories, pending counts and the output valid.
module quad_rotary_encoder_decoder_top import qred_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [3:0]          a_pins,
  input  logic [3:0]          b_pins,
  input  logic [CHAN_W-1:0]   channel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [1:0]   step
);

  logic         accept;
  lane_status_t lane_status [CHANNELS];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic pin_a;
    logic pin_b;
    logic hit;

    if (i < PIN_BITS) begin : g_pin
      assign pin_a = a_pins[i];
      assign pin_b = b_pins[i];
    end else begin : g_low
      // channels past the pin fields see both pins low
      assign pin_a = 1'b0;
      assign pin_b = 1'b0;
    end

    assign hit = (int'(channel) == i);

    qred_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .sample  (accept & ~op),
      .consume (accept & op & hit),
      .a       (pin_a),
      .b       (pin_b),
      .status  (lane_status[i])
    );
  end

  qred_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_status (lane_status),
    .channel     (channel),
    .load        (accept & op),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .step        (step)
  );

endmodule
